### sv/assert_macros.svh
// assertion macros shared by the date adder rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DVAD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define DVAD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/dvad_pkg.sv
// types, constants and microcode table for the date check and day adder
// no dependencies
package dvad_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_YEAR_ZERO = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_PAST_END  = 3'd4,
        ST_NOT_LEAP  = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CHECK,
        OP_CHECK_LEAP,
        OP_ADVANCE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_START,
        COND_BAD,
        COND_NOT_LEAP,
        COND_EXIT,
        COND_ALWAYS
    } cond_t;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE       = 3'd0;
    localparam step_t STEP_CHECK      = 3'd1;
    localparam step_t STEP_CHECK_LEAP = 3'd2;
    localparam step_t STEP_ADVANCE    = 3'd3;
    localparam step_t STEP_EMIT       = 3'd4;

    // one control word per step
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        step_t target;
    } ctrl_t;

    // condition flags from the datapath to the sequencer
    typedef struct packed {
        logic start;
        logic bad;
        logic not_leap;
        logic adv_exit;
    } flags_t;

    localparam logic signed [15:0] YEAR_MAX = 16'sd32767;
    localparam logic [3:0]  DEC          = 4'd12;
    localparam logic [3:0]  FEB          = 4'd2;
    localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;
    localparam logic [4:0]  DAY_MAX      = 5'd31;
    // multiplicative inverse of 25 modulo 2**16 and the divisibility bound
    localparam logic [15:0] INV25        = 16'h5C29;
    localparam logic [15:0] DIV25_LIMIT  = 16'd2621;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        unique case (step)
            STEP_IDLE:       w = '{OP_IDLE,       COND_START,    1'b1, STEP_CHECK};
            STEP_CHECK:      w = '{OP_CHECK,      COND_BAD,      1'b0, STEP_EMIT};
            STEP_CHECK_LEAP: w = '{OP_CHECK_LEAP, COND_NOT_LEAP, 1'b0, STEP_EMIT};
            STEP_ADVANCE:    w = '{OP_ADVANCE,    COND_EXIT,     1'b1, STEP_EMIT};
            STEP_EMIT:       w = '{OP_EMIT,       COND_ALWAYS,   1'b0, STEP_IDLE};
            default:         w = '{OP_EMIT,       COND_ALWAYS,   1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

    // common-year month lengths, zero outside 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     n = 5'd30;
            4'd2:                                        n = 5'd28;
            default:                                     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

### sv/date_validate_and_add_days.sv
// Checks a date (day, month, signed year) and advances it by days_to_add.
// An item is taken when start is high and busy is low; the single result
// appears on status, day_out, month_out and year_out for exactly one cycle
// with done high, and the receiver cannot stall it. After the item is taken,
// the sequencer runs the check step, the leap check step, the advance step,
// which repeats once per month crossed by the advance, and the emit step,
// after which busy drops. A failed range check jumps from the check step
// straight to emit, and 29 February of a common year from the leap check
// step, with a nonzero status and zero date fields.
// depends on dvad_pkg, dvad_seq and assert_macros.svh
`include "assert_macros.svh"

module date_validate_and_add_days (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         day_in,
    input  logic [3:0]         month_in,
    input  logic signed [15:0] year_in,
    input  logic [15:0]        days_to_add,
    output logic               done,
    output logic [2:0]         status,
    output logic [4:0]         day_out,
    output logic [3:0]         month_out,
    output logic signed [15:0] year_out
);
    import dvad_pkg::*;

    ctrl_t  ctrl;
    flags_t flags;

    logic [16:0]        day_reg,    day_next;
    logic [3:0]         month_reg,  month_next;
    logic signed [15:0] year_reg,   year_next;
    logic [15:0]        add_reg,    add_next;
    status_t            status_reg, status_next;
    logic               leap_reg;

    logic [15:0] year_abs;
    logic [15:0] prod;
    logic        div25;
    logic        leap_now;
    status_t     chk_code;
    logic [4:0]  feb_max;
    logic [4:0]  cur_len;
    logic        past_len;
    logic        year_end;
    logic        nleap_bad;

    dvad_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // leap test on |year|: divisible by 25 via the inverse multiply
    assign year_abs = year_reg[15] ? 16'(-year_reg) : 16'(year_reg);
    assign prod     = year_abs * INV25;
    assign div25    = (prod <= DIV25_LIMIT);
    assign leap_now = ((year_abs[1:0] == 2'd0) && !div25) ||
                      ((year_abs[3:0] == 4'd0) && div25);

    assign feb_max = (month_reg == FEB) ? FEB_LEAP_LEN : month_len(month_reg);
    assign cur_len = (month_reg == FEB && leap_reg) ? FEB_LEAP_LEN : month_len(month_reg);
    assign past_len = (day_reg > {12'd0, cur_len});
    assign year_end = (month_reg == DEC);

    always_comb
    begin
        priority if (year_reg == 16'sd0)
            chk_code = ST_YEAR_ZERO;
        else if (month_reg == 4'd0 || month_reg > DEC)
            chk_code = ST_BAD_MONTH;
        else if (day_reg == 17'd0 || day_reg > {12'd0, DAY_MAX})
            chk_code = ST_BAD_DAY;
        else if (day_reg > {12'd0, feb_max})
            chk_code = ST_PAST_END;
        else
            chk_code = ST_OK;
    end

    assign nleap_bad = (month_reg == FEB) && (day_reg == {12'd0, FEB_LEAP_LEN}) && !leap_reg;

    assign flags.start    = start;
    assign flags.bad      = (chk_code != ST_OK);
    assign flags.not_leap = nleap_bad;
    assign flags.adv_exit = !past_len || (year_end && year_reg == YEAR_MAX);

    always_comb
    begin
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        add_next    = add_reg;
        status_next = status_reg;
        unique case (ctrl.op)
            OP_IDLE:
            begin
                if (start)
                begin
                    day_next   = {11'd0, day_in};
                    month_next = month_in;
                    year_next  = year_in;
                    add_next   = days_to_add;
                end
            end
            OP_CHECK:
            begin
                status_next = chk_code;
            end
            OP_CHECK_LEAP:
            begin
                if (nleap_bad)
                    status_next = ST_NOT_LEAP;
                else
                    day_next = day_reg + {1'b0, add_reg};
            end
            OP_ADVANCE:
            begin
                if (past_len)
                begin
                    if (year_end && year_reg == YEAR_MAX)
                    begin
                        status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        day_next = day_reg - {12'd0, cur_len};
                        if (year_end)
                        begin
                            month_next = 4'd1;
                            // there is no year zero
                            year_next  = (year_reg == -16'sd1) ? 16'sd1 : year_reg + 16'sd1;
                        end
                        else
                        begin
                            month_next = month_reg + 4'd1;
                        end
                    end
                end
            end
            OP_EMIT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= ST_OK;
        else
            status_reg <= status_next;
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        add_reg   <= add_next;
        leap_reg  <= leap_now;
    end

    assign busy      = (ctrl.op != OP_IDLE);
    assign done      = (ctrl.op == OP_EMIT);
    assign status    = status_reg;
    assign day_out   = (status_reg == ST_OK) ? day_reg[4:0] : 5'd0;
    assign month_out = (status_reg == ST_OK) ? month_reg : 4'd0;
    assign year_out  = (status_reg == ST_OK) ? year_reg : 16'sd0;

    `DVAD_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `DVAD_ASSERT_NXT(a_done_frees, clk, rst_n, done, !busy && !done)
    `DVAD_ASSERT_IMP(a_fail_zero, clk, rst_n, done && status != ST_OK, day_out == 5'd0 && month_out == 4'd0 && year_out == 16'sd0)
    `DVAD_ASSERT_IMP(a_ok_date, clk, rst_n, done && status == ST_OK, month_out >= 4'd1 && month_out <= DEC && day_out >= 5'd1 && year_out != 16'sd0)

endmodule

### sv/dvad_seq.sv
// microcode sequencer: step counter, control rom and conditional jumps
// depends on dvad_pkg
module dvad_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  dvad_pkg::flags_t flags,
    output dvad_pkg::ctrl_t  ctrl
);
    import dvad_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  take;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_START:    take = flags.start;
            COND_BAD:      take = flags.bad;
            COND_NOT_LEAP: take = flags.not_leap;
            COND_EXIT:     take = flags.adv_exit;
            COND_ALWAYS:   take = 1'b1;
            default:       take = 1'b1;
        endcase
        priority if (take)
            step_next = ctrl.target;
        else if (ctrl.hold)
            step_next = step_reg;
        else
            step_next = step_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule
